FILE: design/ptc_pkg.sv
// Shared types and constants of the periodic timestamp checker.
`default_nettype none

package ptc_pkg;

    localparam int PERIOD_W   = 24;
    localparam int DEV_W      = 24;
    localparam int OUT_CNT_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd33333;

    // Register index taken from paddr[2].
    localparam logic [0:0] REG_PERIOD = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAG,
        ST_DIV,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/ptc_if.sv
// Valid/ready channel interfaces for the timestamp input and the check result.
`default_nettype none

interface ptc_in_if #(
    parameter int TIMESTAMP_BITS = 48
);
    logic                      valid;
    logic                      ready;
    logic [TIMESTAMP_BITS-1:0] timestamp_us;

    modport source (output valid, output timestamp_us, input ready);
    modport sink (input valid, input timestamp_us, output ready);
endinterface

interface ptc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           first_sample;
    logic                           backstep;
    logic                           drop_detected;
    logic [ptc_pkg::OUT_CNT_W-1:0]  frames_dropped;
    logic                           off_time;
    logic [ptc_pkg::DEV_W-1:0]      period_deviation_us;
    logic                           deviation_over_limit;
    logic [ptc_pkg::DEV_W-1:0]      largest_deviation_us;
    logic [ptc_pkg::OUT_CNT_W-1:0]  total_dropped;
    logic [ptc_pkg::OUT_CNT_W-1:0]  total_off_time;
    logic [ptc_pkg::OUT_CNT_W-1:0]  total_backsteps;
    logic [ptc_pkg::OUT_CNT_W-1:0]  total_processed;

    modport source (
        output valid, output first_sample, output backstep, output drop_detected,
        output frames_dropped, output off_time, output period_deviation_us,
        output deviation_over_limit, output largest_deviation_us, output total_dropped,
        output total_off_time, output total_backsteps, output total_processed,
        input ready
    );
    modport sink (
        input valid, input first_sample, input backstep, input drop_detected,
        input frames_dropped, input off_time, input period_deviation_us,
        input deviation_over_limit, input largest_deviation_us, input total_dropped,
        input total_off_time, input total_backsteps, input total_processed,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/ptc_cfg.sv
// APB configuration register holding the nominal period.
`default_nettype none

module ptc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ptc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ptc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ptc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [ptc_pkg::PERIOD_W-1:0]    o_period
);

    logic [ptc_pkg::PERIOD_W-1:0] r_period;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == ptc_pkg::REG_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ptc_pkg::PERIOD_RESET;
        end else if (w_wr) begin
            r_period <= pwdata[ptc_pkg::PERIOD_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == ptc_pkg::REG_PERIOD) begin
            prdata = ptc_pkg::APB_DATA_W'(r_period);
        end else begin
            prdata = '0;
        end
    end

    assign o_period = r_period;

endmodule

`default_nettype wire

FILE: design/ptc_div.sv
// Bit-serial restoring divider of a timestamp-wide value by the period.
`default_nettype none

module ptc_div #(
    parameter int TIMESTAMP_BITS = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [TIMESTAMP_BITS-1:0]       i_dividend,
    input  wire logic [ptc_pkg::PERIOD_W-1:0]    i_divisor,
    output logic                                 o_done,
    output logic      [TIMESTAMP_BITS-1:0]       o_quot,
    output logic      [ptc_pkg::PERIOD_W-1:0]    o_rem
);

    localparam int CW = $clog2(TIMESTAMP_BITS + 1);
    localparam int PW = ptc_pkg::PERIOD_W;

    logic [TIMESTAMP_BITS-1:0] r_quo;
    logic [PW-1:0]             r_rem;
    logic [PW-1:0]             r_div;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [PW:0]               w_sh;
    logic [PW:0]               w_diff;
    logic                      w_fit;

    assign w_sh   = {r_rem, r_quo[TIMESTAMP_BITS-1]};
    assign w_diff = w_sh - {1'b0, r_div};
    assign w_fit  = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(TIMESTAMP_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIMESTAMP_BITS-2:0], w_fit};
            r_rem <= w_fit ? w_diff[PW-1:0] : w_sh[PW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/periodic_timestamp_checker.sv
// Top level of the periodic timestamp checker: sequencer, checks and counters.
//
// Usage: timestamps enter on the i_sample valid/ready channel, one per item.
// Each accepted item produces exactly one result on the o_result channel with
// the per-item flags, the period deviation and the running totals.
// The nominal period is written over the APB port at byte address 0; the
// user must write it only while the block is idle, as the block itself does
// not enforce this. A period of zero acts as a period of one.
// An item that seeds the reference goes from the prepare step straight to
// the done step; any other item also passes the magnitude, divide and
// evaluate steps, and the bit-serial divider resolves one quotient bit per
// cycle. The next item can be accepted in the cycle after a result is registered.
// i_sample.ready is high only while the sequencer is idle, so one item is in
// work at a time. The result sits in an output register; the next item is
// accepted while it waits, and that item holds in its last step until the
// receiver takes the earlier result.
// Reset is synchronous and active low. It restores the period to 33333 us
// and clears the reference timestamp, the largest deviation and all counters,
// so the first item after reset seeds the reference. Counters saturate.
`default_nettype none

module periodic_timestamp_checker #(
    parameter int TIMESTAMP_BITS = 48,
    parameter int COUNTER_BITS   = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ptc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ptc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ptc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    ptc_in_if.sink                               i_sample,
    ptc_out_if.source                            o_result
);

    localparam int TSB = TIMESTAMP_BITS;
    localparam int CB  = COUNTER_BITS;
    localparam int PW  = ptc_pkg::PERIOD_W;
    localparam int DW  = ptc_pkg::DEV_W;
    localparam int MW  = TSB + 4;
    localparam int QW  = (TSB + 1 > CB) ? TSB + 1 : CB;
    localparam int OW  = ptc_pkg::OUT_CNT_W;

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    ptc_pkg::t_state r_state;
    ptc_pkg::t_state n_state;

    logic [PW-1:0]  w_period;
    logic [PW-1:0]  w_p;
    logic           w_in_fire;
    logic           w_out_free;
    logic           w_in_ready;
    logic           w_div_start;
    logic           w_commit;

    logic [TSB-1:0] r_ts;
    logic [TSB-1:0] r_prev;
    logic           r_seed;
    logic           r_ge;
    logic [TSB-1:0] r_gap;
    logic           r_late;
    logic [TSB-1:0] r_mag;

    logic           r_first;
    logic           r_nonmono;
    logic           r_drop;
    logic           r_terr;
    logic [DW-1:0]  r_pdev;
    logic           r_over;
    logic [CB-1:0]  r_q;

    logic           r_o_first;
    logic           r_o_nonmono;
    logic           r_o_drop;
    logic           r_o_terr;
    logic [DW-1:0]  r_o_pdev;
    logic           r_o_over;
    logic [CB-1:0]  r_o_q;
    logic           r_out_valid;

    logic [DW-1:0]  r_largest;
    logic [CB-1:0]  r_dropped_sum;
    logic [CB-1:0]  r_terr_cnt;
    logic [CB-1:0]  r_nonmono_cnt;
    logic [CB-1:0]  r_proc_cnt;

    logic [TSB:0]   w_d1;
    logic [TSB-1:0] w_d2;
    logic           w_late;
    logic [TSB-1:0] w_mag;
    logic [TSB-1:0] w_dividend;

    logic           w_div_done;
    logic [TSB-1:0] w_quot;
    logic [PW-1:0]  w_rem;

    logic [PW-1:0]  w_other;
    logic [DW-1:0]  w_pdev;
    logic [DW+2:0]  w_pdev5;
    logic [MW-1:0]  w_mag5;
    logic [MW-1:0]  w_mag10;
    logic           w_drop;
    logic           w_terr;
    logic           w_round;
    logic [QW-1:0]  w_q_ext;
    logic [QW-1:0]  w_q_max;
    logic [QW-1:0]  w_q_sat;

    ptc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_period (w_period)
    );

    assign w_p = (w_period == '0) ? PW'(1) : w_period;

    assign w_in_fire  = i_sample.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptc_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ptc_pkg::ST_PREP;
                end
            end
            ptc_pkg::ST_PREP: begin
                n_state = (r_prev == '0) ? ptc_pkg::ST_DONE : ptc_pkg::ST_MAG;
            end
            ptc_pkg::ST_MAG: begin
                n_state = ptc_pkg::ST_DIV;
            end
            ptc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = ptc_pkg::ST_EVAL;
                end
            end
            ptc_pkg::ST_EVAL: begin
                n_state = ptc_pkg::ST_DONE;
            end
            ptc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = ptc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            ptc_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ptc_pkg::ST_MAG: begin
                w_div_start = 1'b1;
            end
            ptc_pkg::ST_DONE: begin
                w_commit = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Gap magnitude and direction relative to the reference timestamp.
    assign w_d1 = {1'b0, r_ts} - {1'b0, r_prev};
    assign w_d2 = r_prev - r_ts;

    assign w_late     = (r_gap >= TSB'(w_p));
    assign w_mag      = w_late ? (r_gap - TSB'(w_p)) : (TSB'(w_p) - r_gap);
    assign w_dividend = r_ge ? w_mag : r_gap;

    ptc_div #(
        .TIMESTAMP_BITS (TSB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_p),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Threshold x > floor(P/k) is the same as k*x > P for integer x.
    assign w_other = w_p - w_rem;
    assign w_pdev  = DW'((w_rem < w_other) ? w_rem : w_other);
    assign w_pdev5 = ((DW+3)'(w_pdev) << 2) + (DW+3)'(w_pdev);
    assign w_mag5  = (MW'(r_mag) << 2) + MW'(r_mag);
    assign w_mag10 = w_mag5 << 1;
    assign w_drop  = r_late && (w_mag5 > MW'(w_p));
    assign w_terr  = !w_drop && (!r_ge || (w_mag10 > MW'(w_p)));
    assign w_round = ({1'b0, w_rem} << 1) >= {1'b0, w_p};
    assign w_q_ext = QW'(w_quot) + QW'(w_round);
    assign w_q_max = QW'({CB{1'b1}});

    always_comb begin
        if (w_q_ext == '0) begin
            w_q_sat = QW'(1);
        end else if (w_q_ext > w_q_max) begin
            w_q_sat = w_q_max;
        end else begin
            w_q_sat = w_q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ptc_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    r_ts <= i_sample.timestamp_us;
                end
            end
            ptc_pkg::ST_PREP: begin
                r_seed    <= (r_prev == '0);
                r_ge      <= !w_d1[TSB];
                r_gap     <= w_d1[TSB] ? w_d2 : w_d1[TSB-1:0];
                r_first   <= (r_prev == '0);
                r_nonmono <= (r_prev != '0) && (w_d1[TSB] || (w_d1 == '0));
                r_drop    <= 1'b0;
                r_terr    <= 1'b0;
                r_pdev    <= '0;
                r_over    <= 1'b0;
                r_q       <= '0;
            end
            ptc_pkg::ST_MAG: begin
                r_late <= r_ge && w_late;
                r_mag  <= w_mag;
            end
            ptc_pkg::ST_EVAL: begin
                r_drop <= w_drop;
                r_terr <= w_terr;
                r_pdev <= w_pdev;
                r_over <= (w_pdev5 > (DW+3)'(w_p));
                r_q    <= w_drop ? CB'(w_q_sat) : '0;
            end
            default: begin
                r_seed <= r_seed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_first   <= r_first;
            r_o_nonmono <= r_nonmono;
            r_o_drop    <= r_drop;
            r_o_terr    <= r_terr;
            r_o_pdev    <= r_pdev;
            r_o_over    <= r_over;
            r_o_q       <= r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_prev        <= '0;
            r_largest     <= '0;
            r_dropped_sum <= '0;
            r_terr_cnt    <= '0;
            r_nonmono_cnt <= '0;
            r_proc_cnt    <= '0;
        end else begin
            if (w_commit) begin
                r_out_valid   <= 1'b1;
                r_prev        <= r_ts;
                r_dropped_sum <= sat_add(r_dropped_sum, r_q);
                r_terr_cnt    <= sat_add(r_terr_cnt, CB'(r_terr));
                r_nonmono_cnt <= sat_add(r_nonmono_cnt, CB'(r_nonmono));
                r_proc_cnt    <= sat_add(r_proc_cnt, CB'(1));
                if (!r_seed && (r_pdev > r_largest)) begin
                    r_largest <= r_pdev;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_sample.ready = w_in_ready;

    assign o_result.valid                = r_out_valid;
    assign o_result.first_sample         = r_o_first;
    assign o_result.backstep             = r_o_nonmono;
    assign o_result.drop_detected        = r_o_drop;
    assign o_result.frames_dropped       = OW'(r_o_q);
    assign o_result.off_time             = r_o_terr;
    assign o_result.period_deviation_us  = r_o_pdev;
    assign o_result.deviation_over_limit = r_o_over;
    assign o_result.largest_deviation_us = r_largest;
    assign o_result.total_dropped        = OW'(r_dropped_sum);
    assign o_result.total_off_time       = OW'(r_terr_cnt);
    assign o_result.total_backsteps      = OW'(r_nonmono_cnt);
    assign o_result.total_processed      = OW'(r_proc_cnt);

endmodule

`default_nettype wire
